FILE: design/frs_pkg.sv
package frs_pkg;

    localparam logic [7:0]  START_BYTE          = 8'hAA;
    localparam logic [7:0]  MAX_LENGTH_RESET    = 8'hFF;
    localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'h0FFF;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;

    localparam logic [0:0] REG_MAX_LENGTH    = 1'b0;
    localparam logic [0:0] REG_TIMEOUT_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_OK       = 3'd1,
        KIND_TOO_LONG = 3'd2,
        KIND_TIMEOUT  = 3'd3,
        KIND_BAD_SUM  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  max_length;
        logic [15:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } result_t;

endpackage

FILE: design/frs_cfg_regs.sv
module frs_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output frs_pkg::cfg_t     cfg
);
    import frs_pkg::*;

    logic [7:0]  max_length_reg;
    logic [15:0] timeout_limit_reg;
    logic        wr_en;
    logic [0:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg    <= MAX_LENGTH_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MAX_LENGTH:    max_length_reg    <= pwdata[7:0];
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_MAX_LENGTH:    prdata = {24'd0, max_length_reg};
            REG_TIMEOUT_LIMIT: prdata = {16'd0, timeout_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.max_length    = max_length_reg;
    assign cfg.timeout_limit = timeout_limit_reg;

endmodule

FILE: design/frs_deframer.sv
module frs_deframer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              opcode,
    input  logic [7:0]        rx_byte,
    input  frs_pkg::cfg_t     cfg,
    output logic              res_valid,
    output frs_pkg::result_t  res
);
    import frs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  taken_reg, taken_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] idle_reg, idle_next;

    logic        is_tick;
    logic [16:0] idle_cnt;
    logic        timeout_hit;
    logic        too_long_hit;
    logic [8:0]  taken_inc;
    logic        data_last;

    assign is_tick      = (opcode == OP_TICK);
    assign idle_cnt     = {1'b0, idle_reg} + 17'd1;
    assign timeout_hit  = is_tick && (idle_cnt >= {1'b0, cfg.timeout_limit});
    assign too_long_hit = (rx_byte > cfg.max_length);
    assign taken_inc    = {1'b0, taken_reg} + 9'd1;
    assign data_last    = (taken_inc >= {1'b0, len_reg});

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: begin
                if (!is_tick && rx_byte == START_BYTE) phase_next = PH_LEN;
            end
            PH_LEN: begin
                if (timeout_hit) phase_next = PH_HUNT;
                else if (!is_tick) begin
                    if (too_long_hit)       phase_next = PH_HUNT;
                    else if (rx_byte == '0) phase_next = PH_SUM;
                    else                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                if (timeout_hit) phase_next = PH_HUNT;
                else if (!is_tick && data_last) phase_next = PH_SUM;
            end
            PH_SUM: begin
                if (timeout_hit || !is_tick) phase_next = PH_HUNT;
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    always_comb begin
        len_next   = len_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        idle_next  = idle_reg;
        res_valid  = 1'b0;
        res        = '{KIND_PAYLOAD, 8'd0, 8'd0, 8'd0};
        if (phase_reg == PH_HUNT) begin
            if (!is_tick && rx_byte == START_BYTE) begin
                len_next   = '0;
                taken_next = '0;
                sum_next   = '0;
                idle_next  = '0;
            end
        end else if (is_tick) begin
            if (timeout_hit) begin
                len_next   = '0;
                taken_next = '0;
                sum_next   = '0;
                idle_next  = '0;
                res_valid  = 1'b1;
                res.result_kind  = KIND_TIMEOUT;
                res.frame_length = (phase_reg == PH_LEN) ? 8'd0 : len_reg;
            end else begin
                idle_next = idle_cnt[15:0];
            end
        end else begin
            idle_next = '0;
            case (phase_reg)
                PH_LEN: begin
                    if (too_long_hit) begin
                        len_next   = '0;
                        taken_next = '0;
                        sum_next   = '0;
                        res_valid  = 1'b1;
                        res.result_kind  = KIND_TOO_LONG;
                        res.frame_length = rx_byte;
                    end else begin
                        len_next   = rx_byte;
                        sum_next   = rx_byte;
                        taken_next = '0;
                    end
                end
                PH_DATA: begin
                    sum_next   = sum_reg + rx_byte;
                    taken_next = taken_inc[7:0];
                    res_valid  = 1'b1;
                    res.result_kind  = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                    res.byte_index   = taken_reg;
                    res.frame_length = len_reg;
                end
                default: begin
                    len_next   = '0;
                    taken_next = '0;
                    sum_next   = '0;
                    res_valid  = 1'b1;
                    res.result_kind  = (rx_byte == sum_reg) ? KIND_OK : KIND_BAD_SUM;
                    res.frame_length = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            taken_reg <= '0;
            sum_reg   <= '0;
            idle_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

FILE: design/frs_out_stage.sv
module frs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              step,
    input  logic              res_valid,
    input  frs_pkg::result_t  res,
    output logic              m_valid,
    input  logic              m_ready,
    output frs_pkg::result_t  m_res
);
    import frs_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign s_ready = !valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (step)         valid_next = res_valid;
        else if (m_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) res_reg <= res;
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

FILE: design/frame_receiver_sum_checksum.sv
// A result beat is valid on m_valid in the cycle after the input beat that causes it is accepted.
// Throughput: one input beat per cycle; the phase and counter registers update in one step.
// Input stalls only while a result beat waits and m_ready is low.
// Reset (aresetn low, synchronous): hunting for the start byte, no result pending,
// max_length 255, timeout_limit 4095.
module frame_receiver_sum_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_byte_index,
    output logic [7:0]  m_frame_length
);
    import frs_pkg::*;

    cfg_t    cfg;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t m_res;

    frs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    frs_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .opcode    (s_opcode),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    frs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_result_kind  = m_res.result_kind;
    assign m_payload_byte = m_res.payload_byte;
    assign m_byte_index   = m_res.byte_index;
    assign m_frame_length = m_res.frame_length;

endmodule
